>>> design/sstf_pkg.sv
// Shared types and constants for the SSTF disk request scheduler.
package sstf_pkg;

    // Fixed field widths
    localparam int REQ_W   = 5;
    localparam int TRK_W   = 10;
    localparam int ENTRY_W = REQ_W + TRK_W;
    localparam int MAXQ_W  = 5;
    localparam int ACTR_W  = 6;
    localparam int CFGD_W  = 6;
    localparam int STAT_W  = 2;
    localparam int QCNT_W  = 5;
    localparam int ALIVE_W = 6;

    // Configuration register reset values
    localparam logic [MAXQ_W-1:0] MAX_QUEUE_RESET  = 5'd16;
    localparam logic [ACTR_W-1:0] ACTIVE_REQ_RESET = 6'd32;

    // Configuration register indexes
    typedef enum logic {
        CFG_MAX_QUEUE  = 1'b0,
        CFG_ACTIVE_REQ = 1'b1
    } t_cfg_idx;

    // Item opcodes
    typedef enum logic {
        OP_SUBMIT = 1'b0,
        OP_FINISH = 1'b1
    } t_opcode;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_BUSY    = 2'd1,
        ST_FULL    = 2'd2,
        ST_REFUSED = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SETTLE,
        S_DECIDE,
        S_SCAN,
        S_TAKE,
        S_MOVE,
        S_OUT
    } t_state;

    // Control of the shared seek-distance unit
    typedef struct packed {
        logic en;     // compare the entry on the read port
        logic first;  // entry is slot 0: always taken
    } t_seek_ctrl;

endpackage

>>> design/sstf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sstf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/sstf_seek_unit.sv
// Shared seek-distance compare unit: keeps the nearest slot seen during a scan.
module sstf_seek_unit #(
    parameter int AW = 4
) (
    input  logic                       i_clk,
    input  sstf_pkg::t_seek_ctrl       i_ctrl,
    input  logic [AW-1:0]              i_idx,
    input  logic [sstf_pkg::ENTRY_W-1:0] i_entry,
    input  logic [sstf_pkg::TRK_W-1:0] i_head,
    output logic [AW-1:0]              o_best_idx,
    output logic [sstf_pkg::ENTRY_W-1:0] o_best_entry
);

    logic [sstf_pkg::TRK_W-1:0]   trk;
    logic [sstf_pkg::TRK_W-1:0]   gap;
    logic                         take;
    logic [AW-1:0]                r_best_idx;
    logic [sstf_pkg::TRK_W-1:0]   r_best_dist;
    logic [sstf_pkg::ENTRY_W-1:0] r_best_entry;

    // Absolute distance from head, strict less-than keeps the lowest slot on ties
    always_comb begin
        trk  = i_entry[sstf_pkg::TRK_W-1:0];
        gap  = (trk > i_head) ? (trk - i_head) : (i_head - trk);
        take = i_ctrl.en && (i_ctrl.first || (gap < r_best_dist));
    end

    // Best-so-far registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_idx   <= i_idx;
            r_best_dist  <= gap;
            r_best_entry <= i_entry;
        end
    end

    assign o_best_idx   = r_best_idx;
    assign o_best_entry = r_best_entry;

endmodule

>>> design/sstf_disk_request_scheduler.sv
// SSTF disk request scheduler: sequencer, queue state and result registers.
// A rejected item goes from CHECK straight to OUT; an accepted one without a serve goes
// through SETTLE and DECIDE to OUT, and one with a serve adds the slot scan, TAKE and MOVE.
// One item at a time: busy until the o_done cycle ends; o_done cannot stall.
// Synchronous active-low reset empties the queue, clears both masks, homes the head
// to track 0 and loads the configuration registers with 16 and 32.
module sstf_disk_request_scheduler #(
    parameter int QUEUE_DEPTH = 16,
    parameter int REQUESTERS  = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // command channel
    input  logic       start,
    output logic       busy,
    input  logic [0:0] i_opcode,
    input  logic [4:0] i_requester,
    input  logic [9:0] i_track,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [5:0] i_cfg_data,
    // result
    output logic       o_done,
    output logic [1:0] o_status,
    output logic       o_served_valid,
    output logic [4:0] o_served_requester,
    output logic [9:0] o_served_track,
    output logic [4:0] o_queue_count,
    output logic [5:0] o_alive_count
);

    localparam int AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int HW  = $clog2(QUEUE_DEPTH + 1);
    localparam int CW  = $clog2(REQUESTERS + 1);
    localparam int RIW = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;

    sstf_pkg::t_state r_state, n_state;

    // configuration
    logic [sstf_pkg::MAXQ_W-1:0] r_max_queue;
    logic [sstf_pkg::ACTR_W-1:0] r_active;

    // latched item
    logic                        r_op;
    logic [sstf_pkg::REQ_W-1:0]  r_req;
    logic [sstf_pkg::TRK_W-1:0]  r_trk;

    // queue and requester state
    logic [HW-1:0]               r_held;
    logic [sstf_pkg::TRK_W-1:0]  r_head;
    logic [REQUESTERS-1:0]       r_outst;
    logic [REQUESTERS-1:0]       r_finished;
    logic [CW-1:0]               r_alive;

    // scan control
    logic [HW-1:0]               r_ridx;
    logic [AW-1:0]               r_cidx;
    logic                        r_cv;

    // result
    sstf_pkg::t_status           r_status;
    logic                        r_sv;
    logic [sstf_pkg::REQ_W-1:0]  r_sreq;
    logic [sstf_pkg::TRK_W-1:0]  r_strk;

    // combinational
    logic [HW-1:0]               eff_lim;
    logic [CW-1:0]               eff_req;
    logic [CW-1:0]               alive_cnt;
    logic                        present;
    logic                        finished;
    logic                        req_busy;
    logic [RIW-1:0]              req_bit;
    logic [RIW-1:0]              srv_bit;
    sstf_pkg::t_status           chk_status;
    logic                        serve;
    logic                        scan_issue;

    // RAM and seek unit wiring
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [sstf_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [sstf_pkg::ENTRY_W-1:0]  ram_rdata;
    sstf_pkg::t_seek_ctrl          seek_ctrl;
    logic [AW-1:0]                 best_idx;
    logic [sstf_pkg::ENTRY_W-1:0]  best_entry;

    // Effective limits: queue limit clamped to 1..depth, requester count to REQUESTERS
    always_comb begin
        if (r_max_queue == '0) begin
            eff_lim = HW'(1);
        end else if (int'(r_max_queue) > QUEUE_DEPTH) begin
            eff_lim = HW'(QUEUE_DEPTH);
        end else begin
            eff_lim = HW'(r_max_queue);
        end
        if (int'(r_active) > REQUESTERS) begin
            eff_req = CW'(REQUESTERS);
        end else begin
            eff_req = CW'(r_active);
        end
    end

    // Alive count: present and not finished, registered each cycle
    always_comb begin
        alive_cnt = '0;
        for (int i = 0; i < REQUESTERS; i++) begin
            if ((i < int'(eff_req)) && !r_finished[i]) begin
                alive_cnt = alive_cnt + CW'(1);
            end
        end
    end

    // Admission check on the latched item
    always_comb begin
        req_bit  = RIW'(r_req);
        present  = int'(r_req) < int'(eff_req);
        finished = !present || r_finished[req_bit];
        req_busy = present && r_outst[req_bit];
        if (r_op == sstf_pkg::OP_SUBMIT) begin
            if (finished) begin
                chk_status = sstf_pkg::ST_REFUSED;
            end else if (req_busy) begin
                chk_status = sstf_pkg::ST_BUSY;
            end else if ((r_held >= eff_lim) || (int'(r_held) >= QUEUE_DEPTH)) begin
                chk_status = sstf_pkg::ST_FULL;
            end else begin
                chk_status = sstf_pkg::ST_OK;
            end
        end else begin
            if (finished || req_busy) begin
                chk_status = sstf_pkg::ST_REFUSED;
            end else begin
                chk_status = sstf_pkg::ST_OK;
            end
        end
    end

    // Serve when the count meets min(limit, alive) and the queue is not empty
    always_comb begin
        if (r_held == '0) begin
            serve = 1'b0;
        end else if (int'(eff_lim) < int'(r_alive)) begin
            serve = int'(r_held) == int'(eff_lim);
        end else begin
            serve = int'(r_held) == int'(r_alive);
        end
    end

    assign scan_issue = (r_state == sstf_pkg::S_SCAN) && (r_ridx < r_held);
    assign srv_bit    = RIW'(best_entry[sstf_pkg::ENTRY_W-1:sstf_pkg::TRK_W]);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sstf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and RAM / seek unit control
    always_comb begin
        n_state        = r_state;
        ram_we         = 1'b0;
        ram_waddr      = AW'(r_held);
        ram_wdata      = {r_req, r_trk};
        ram_raddr      = AW'(r_ridx);
        seek_ctrl.en    = 1'b0;
        seek_ctrl.first = 1'b0;
        case (r_state)
            sstf_pkg::S_IDLE: begin
                if (start) begin
                    n_state = sstf_pkg::S_CHECK;
                end
            end
            sstf_pkg::S_CHECK: begin
                if ((chk_status == sstf_pkg::ST_OK) && (r_op == sstf_pkg::OP_SUBMIT)) begin
                    ram_we = 1'b1;
                end
                n_state = (chk_status == sstf_pkg::ST_OK) ? sstf_pkg::S_SETTLE
                                                           : sstf_pkg::S_OUT;
            end
            sstf_pkg::S_SETTLE: begin
                n_state = sstf_pkg::S_DECIDE;
            end
            sstf_pkg::S_DECIDE: begin
                n_state = serve ? sstf_pkg::S_SCAN : sstf_pkg::S_OUT;
            end
            sstf_pkg::S_SCAN: begin
                seek_ctrl.en    = r_cv;
                seek_ctrl.first = (r_cidx == '0);
                if (!r_cv && !scan_issue) begin
                    n_state = sstf_pkg::S_TAKE;
                end
            end
            sstf_pkg::S_TAKE: begin
                // fetch the last entry to refill the freed slot
                ram_raddr = AW'(r_held - HW'(1));
                n_state   = sstf_pkg::S_MOVE;
            end
            sstf_pkg::S_MOVE: begin
                ram_we    = 1'b1;
                ram_waddr = best_idx;
                ram_wdata = ram_rdata;
                n_state   = sstf_pkg::S_OUT;
            end
            sstf_pkg::S_OUT: begin
                n_state = sstf_pkg::S_IDLE;
            end
            default: begin
                n_state = sstf_pkg::S_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_queue <= sstf_pkg::MAX_QUEUE_RESET;
            r_active    <= sstf_pkg::ACTIVE_REQ_RESET;
        end else if (i_cfg_we) begin
            case (sstf_pkg::t_cfg_idx'(i_cfg_idx))
                sstf_pkg::CFG_MAX_QUEUE:  r_max_queue <= i_cfg_data[sstf_pkg::MAXQ_W-1:0];
                sstf_pkg::CFG_ACTIVE_REQ: r_active    <= i_cfg_data[sstf_pkg::ACTR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Queue, mask and head state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '0;
            r_head     <= '0;
            r_outst    <= '0;
            r_finished <= '0;
            r_alive    <= '0;
        end else begin
            r_alive <= alive_cnt;
            if ((r_state == sstf_pkg::S_CHECK) && (chk_status == sstf_pkg::ST_OK)) begin
                if (r_op == sstf_pkg::OP_SUBMIT) begin
                    r_held           <= r_held + HW'(1);
                    r_outst[req_bit] <= 1'b1;
                end else begin
                    r_finished[req_bit] <= 1'b1;
                end
            end
            if (r_state == sstf_pkg::S_TAKE) begin
                r_outst[srv_bit] <= 1'b0;
                r_head           <= best_entry[sstf_pkg::TRK_W-1:0];
            end
            if (r_state == sstf_pkg::S_MOVE) begin
                r_held <= r_held - HW'(1);
            end
        end
    end

    // Item capture, scan counters and result registers
    always_ff @(posedge i_clk) begin
        if ((r_state == sstf_pkg::S_IDLE) && start) begin
            r_op  <= i_opcode[0];
            r_req <= i_requester;
            r_trk <= i_track;
        end
        case (r_state)
            sstf_pkg::S_CHECK: begin
                r_status <= chk_status;
                r_sv     <= 1'b0;
                r_sreq   <= '0;
                r_strk   <= '0;
            end
            sstf_pkg::S_DECIDE: begin
                r_ridx <= '0;
                r_cidx <= '0;
                r_cv   <= 1'b0;
            end
            sstf_pkg::S_SCAN: begin
                r_cv   <= scan_issue;
                r_cidx <= AW'(r_ridx);
                if (scan_issue) begin
                    r_ridx <= r_ridx + HW'(1);
                end
            end
            sstf_pkg::S_TAKE: begin
                r_sv   <= 1'b1;
                r_sreq <= best_entry[sstf_pkg::ENTRY_W-1:sstf_pkg::TRK_W];
                r_strk <= best_entry[sstf_pkg::TRK_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // Slot store
    sstf_ram #(
        .WIDTH (sstf_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Nearest-track search
    sstf_seek_unit #(
        .AW (AW)
    ) u_seek (
        .i_clk        (i_clk),
        .i_ctrl       (seek_ctrl),
        .i_idx        (r_cidx),
        .i_entry      (ram_rdata),
        .i_head       (r_head),
        .o_best_idx   (best_idx),
        .o_best_entry (best_entry)
    );

    // Outputs
    assign busy               = (r_state != sstf_pkg::S_IDLE);
    assign o_done             = (r_state == sstf_pkg::S_OUT);
    assign o_status           = r_status;
    assign o_served_valid     = r_sv;
    assign o_served_requester = r_sreq;
    assign o_served_track     = r_strk;
    assign o_queue_count      = sstf_pkg::QCNT_W'(r_held);
    assign o_alive_count      = sstf_pkg::ALIVE_W'(r_alive);

endmodule

>>> design/sstf_checker.sv
// Port-level checker for the SSTF disk request scheduler, bound to the top level.
module sstf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [1:0] o_status,
    input logic       o_served_valid,
    input logic [9:0] o_served_track
);

    // An accepted command makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // The block is free again right after the result transfer
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("busy still high after result transfer");

    // A result only follows a cycle of work
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without preceding work");

    // A rejected command never serves a request
    a_reject_no_serve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != sstf_pkg::ST_OK)) |-> (!o_served_valid && (o_served_track == '0)))
        else $error("serve reported on a rejected command");

endmodule

bind sstf_disk_request_scheduler sstf_checker u_sstf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_status       (o_status),
    .o_served_valid (o_served_valid),
    .o_served_track (o_served_track)
);

>>> verif/sstf_disk_request_scheduler_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the SSTF disk request scheduler.
module sstf_disk_request_scheduler_tb;

    localparam int QDEPTH    = 16;
    localparam int NREQ      = 32;
    localparam int MAX_SHOWN = 10;
    localparam int PHASE_LEN = 235;
    localparam logic [sstf_pkg::TRK_W-1:0] TRK_TOP = 10'd999;

    // One command and the result it should produce
    typedef struct packed {
        sstf_pkg::t_opcode          op;
        logic [sstf_pkg::REQ_W-1:0] who;
        logic [sstf_pkg::TRK_W-1:0] trk;
    } t_cmd;

    typedef struct packed {
        sstf_pkg::t_status            status;
        logic                         served;
        logic [sstf_pkg::REQ_W-1:0]   served_who;
        logic [sstf_pkg::TRK_W-1:0]   served_trk;
        logic [sstf_pkg::QCNT_W-1:0]  held;
        logic [sstf_pkg::ALIVE_W-1:0] alive;
    } t_outcome;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [0:0] i_opcode = sstf_pkg::OP_SUBMIT;
    logic [4:0] i_requester = '0;
    logic [9:0] i_track = '0;
    logic i_cfg_we = 1'b0;
    logic [0:0] i_cfg_idx = sstf_pkg::CFG_MAX_QUEUE;
    logic [5:0] i_cfg_data = '0;
    logic o_done;
    logic [1:0] o_status;
    logic o_served_valid;
    logic [4:0] o_served_requester;
    logic [9:0] o_served_track;
    logic [4:0] o_queue_count;
    logic [5:0] o_alive_count;

    sstf_disk_request_scheduler i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_opcode           (i_opcode),
        .i_requester        (i_requester),
        .i_track            (i_track),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_served_valid     (o_served_valid),
        .o_served_requester (o_served_requester),
        .o_served_track     (o_served_track),
        .o_queue_count      (o_queue_count),
        .o_alive_count      (o_alive_count)
    );

    // Scheduler shadow state
    logic [sstf_pkg::MAXQ_W-1:0] cfg_max_queue;
    logic [sstf_pkg::ACTR_W-1:0] cfg_active;
    logic [sstf_pkg::REQ_W-1:0]  q_who [QDEPTH];
    logic [sstf_pkg::TRK_W-1:0]  q_trk [QDEPTH];
    int unsigned                 q_held;
    logic [sstf_pkg::TRK_W-1:0]  head_pos;
    logic [NREQ-1:0]             pending_mask;
    logic [NREQ-1:0]             retired_mask;

    t_cmd     cmd_backlog [$];
    t_outcome due_outcomes [$];
    t_cmd     cur_cmd;
    t_cmd     drv_next;
    logic     drv_load;
    bit       steady = 1'b0;

    int n_errors   = 0;
    int n_taken    = 0;
    int n_checked  = 0;
    int n_serves   = 0;
    int n_rejects  = 0;
    int n_settings = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned queue_limit();
        if (cfg_max_queue < 1) return 1;
        if (cfg_max_queue > QDEPTH) return QDEPTH;
        return cfg_max_queue;
    endfunction

    function automatic int unsigned present_count();
        return (cfg_active > NREQ) ? NREQ : cfg_active;
    endfunction

    function automatic int unsigned alive_total();
        int unsigned n;
        n = 0;
        for (int i = 0; i < present_count(); i++)
            if (!retired_mask[i]) n++;
        return n;
    endfunction

    // Apply one command to the shadow state; nearest track wins, ties to lowest slot
    function automatic t_outcome schedule_cmd(t_cmd c);
        t_outcome    r;
        logic        gone;
        logic        waiting;
        int unsigned target;
        int unsigned pick;
        int unsigned best_dist;
        int unsigned gap;
        r.status     = sstf_pkg::ST_OK;
        r.served     = 1'b0;
        r.served_who = '0;
        r.served_trk = '0;
        gone    = (c.who >= present_count()) || retired_mask[c.who];
        waiting = pending_mask[c.who];
        if (c.op == sstf_pkg::OP_SUBMIT) begin
            if (gone) r.status = sstf_pkg::ST_REFUSED;
            else if (waiting) r.status = sstf_pkg::ST_BUSY;
            else if (q_held >= queue_limit()) r.status = sstf_pkg::ST_FULL;
            else begin
                q_who[q_held] = c.who;
                q_trk[q_held] = c.trk;
                q_held++;
                pending_mask[c.who] = 1'b1;
            end
        end else begin
            if (gone || waiting) r.status = sstf_pkg::ST_REFUSED;
            else retired_mask[c.who] = 1'b1;
        end
        // serve only on an exact match of count and target
        if (r.status == sstf_pkg::ST_OK) begin
            target = (queue_limit() < alive_total()) ? queue_limit() : alive_total();
            if (q_held == target && q_held > 0) begin
                pick = 0;
                best_dist = 0;
                for (int i = 0; i < q_held; i++) begin
                    gap = (q_trk[i] > head_pos) ? q_trk[i] - head_pos : head_pos - q_trk[i];
                    if (i == 0 || gap < best_dist) begin
                        best_dist = gap;
                        pick = i;
                    end
                end
                r.served     = 1'b1;
                r.served_who = q_who[pick];
                r.served_trk = q_trk[pick];
                pending_mask[q_who[pick]] = 1'b0;
                head_pos     = q_trk[pick];
                q_who[pick]  = q_who[q_held-1];
                q_trk[pick]  = q_trk[q_held-1];
                q_held--;
            end
        end
        r.held  = sstf_pkg::QCNT_W'(q_held);
        r.alive = sstf_pkg::ALIVE_W'(alive_total());
        return r;
    endfunction

    task automatic flag_error(string what);
        n_errors++;
        if (n_errors <= MAX_SHOWN) $display("ERROR at %0t: %s", $time, what);
    endtask

    task automatic push_cmd(sstf_pkg::t_opcode op, logic [sstf_pkg::REQ_W-1:0] who,
                            logic [sstf_pkg::TRK_W-1:0] trk);
        t_cmd c;
        c.op  = op;
        c.who = who;
        c.trk = trk;
        cmd_backlog = {cmd_backlog, c};
    endtask

    // Register write; shadow copy updated as the write is driven
    task automatic write_cfg(sstf_pkg::t_cfg_idx idx, logic [sstf_pkg::CFGD_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == sstf_pkg::CFG_MAX_QUEUE) cfg_max_queue = data[sstf_pkg::MAXQ_W-1:0];
        else cfg_active = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every command is through and every result is in
    task automatic settle();
        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || start || busy || due_outcomes.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // New register setting, then a burst of mostly well-formed submits
    task automatic run_phase(logic [sstf_pkg::CFGD_W-1:0] qlim,
                             logic [sstf_pkg::CFGD_W-1:0] nreq, bit calm, int n_cmds);
        int unsigned                span;
        logic [sstf_pkg::REQ_W-1:0] who;
        logic [sstf_pkg::TRK_W-1:0] trk;
        write_cfg(sstf_pkg::CFG_MAX_QUEUE, qlim);
        write_cfg(sstf_pkg::CFG_ACTIVE_REQ, nreq);
        n_settings++;
        steady = calm;
        span = present_count();
        for (int k = 0; k < n_cmds; k++) begin
            if ($urandom_range(9) == 0) trk = $urandom_range(1) ? TRK_TOP : '0;
            else trk = sstf_pkg::TRK_W'($urandom_range(999, 0));
            // retirements kept rare and to the upper ids
            if ($urandom_range(99) < 3) begin
                push_cmd(sstf_pkg::OP_FINISH, sstf_pkg::REQ_W'($urandom_range(31, 16)), trk);
            end else begin
                if (span > 0 && $urandom_range(99) < 85)
                    who = sstf_pkg::REQ_W'($urandom_range(span - 1, 0));
                else who = sstf_pkg::REQ_W'($urandom_range(31, 0));
                push_cmd(sstf_pkg::OP_SUBMIT, who, trk);
            end
        end
        settle();
    endtask

    // Driver: presents commands, predicts on each accepted transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            drv_load = !start;
            if (start && !busy) begin
                due_outcomes = {due_outcomes, schedule_cmd(cur_cmd)};
                n_taken++;
                drv_load = 1'b1;
            end
            if (drv_load) begin
                if (cmd_backlog.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
                    drv_next    = cmd_backlog.pop_front();
                    cur_cmd     = drv_next;
                    start       <= 1'b1;
                    i_opcode    <= drv_next.op;
                    i_requester <= drv_next.who;
                    i_track     <= drv_next.trk;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: each strobed result against the oldest prediction
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_done) begin
            if (due_outcomes.size() == 0) begin
                flag_error("result with no prediction outstanding");
            end else begin
                want = due_outcomes.pop_front();
                n_checked++;
                if (o_served_valid) n_serves++;
                if (o_status != sstf_pkg::ST_OK) n_rejects++;
                if (o_status !== want.status || o_served_valid !== want.served ||
                    o_served_requester !== want.served_who ||
                    o_served_track !== want.served_trk ||
                    o_queue_count !== want.held || o_alive_count !== want.alive)
                    flag_error($sformatf({"result %0d: exp st=%0d sv=%0b rq=%0d tr=%0d q=%0d ",
                        "al=%0d, got st=%0d sv=%0b rq=%0d tr=%0d q=%0d al=%0d"}, n_checked,
                        want.status, want.served, want.served_who, want.served_trk, want.held,
                        want.alive, o_status, o_served_valid, o_served_requester,
                        o_served_track, o_queue_count, o_alive_count));
            end
        end
    end

    // Stimulus
    initial begin
        int pick_id;
        cfg_max_queue = sstf_pkg::MAX_QUEUE_RESET;
        cfg_active    = sstf_pkg::ACTIVE_REQ_RESET;
        q_held        = 0;
        head_pos      = '0;
        pending_mask  = '0;
        retired_mask  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // small queue: busy requester, serves, tie to lowest slot, retirement refusals
        run_phase(6'd3, 6'd63, 1'b0, 0);
        push_cmd(sstf_pkg::OP_SUBMIT, 5'd0, TRK_TOP);
        push_cmd(sstf_pkg::OP_SUBMIT, 5'd0, 10'd5);
        push_cmd(sstf_pkg::OP_SUBMIT, 5'd1, 10'd0);
        push_cmd(sstf_pkg::OP_SUBMIT, 5'd2, TRK_TOP);
        push_cmd(sstf_pkg::OP_SUBMIT, 5'd3, TRK_TOP);
        push_cmd(sstf_pkg::OP_FINISH, 5'd31, 10'd0);
        push_cmd(sstf_pkg::OP_SUBMIT, 5'd31, 10'd7);
        push_cmd(sstf_pkg::OP_FINISH, 5'd31, 10'd0);
        push_cmd(sstf_pkg::OP_FINISH, 5'd2, 10'd0);
        settle();
        // zero queue limit saturates to one: queue already over it
        run_phase(6'd0, 6'd63, 1'b0, 0);
        push_cmd(sstf_pkg::OP_SUBMIT, 5'd5, 10'd512);
        settle();
        // no requesters present at all
        run_phase(6'd31, 6'd0, 1'b0, 0);
        push_cmd(sstf_pkg::OP_SUBMIT, 5'd0, 10'd1);
        push_cmd(sstf_pkg::OP_FINISH, 5'd0, 10'd0);
        settle();
        // few requesters: absent ids refused, serves from the far end of the disk
        run_phase(6'd3, 6'd4, 1'b0, 0);
        push_cmd(sstf_pkg::OP_SUBMIT, 5'd0, 10'd500);
        push_cmd(sstf_pkg::OP_SUBMIT, 5'd7, 10'd1);
        push_cmd(sstf_pkg::OP_FINISH, 5'd7, 10'd0);
        push_cmd(sstf_pkg::OP_SUBMIT, 5'd1, 10'd600);
        settle();

        // random traffic over a spread of settings
        run_phase(6'd16, 6'd32, 1'b0, PHASE_LEN);
        run_phase(6'd1, 6'd32, 1'b0, PHASE_LEN);
        run_phase(6'd31, 6'd63, 1'b1, PHASE_LEN);
        run_phase(6'd4, 6'd6, 1'b0, PHASE_LEN);
        run_phase(6'd2, 6'd32, 1'b0, PHASE_LEN);
        run_phase(6'd0, 6'd1, 1'b0, PHASE_LEN);
        run_phase(6'd8, 6'd20, 1'b0, PHASE_LEN);
        run_phase(6'd16, 6'd32, 1'b0, PHASE_LEN);

        // retire every idle requester in turn until nobody is left; the last one
        // lands on an empty queue with a zero target
        do begin
            pick_id = -1;
            for (int i = NREQ - 1; i >= 0; i--)
                if (i < present_count() && !retired_mask[i] && !pending_mask[i]) pick_id = i;
            if (pick_id >= 0) begin
                push_cmd(sstf_pkg::OP_FINISH, pick_id[sstf_pkg::REQ_W-1:0],
                         sstf_pkg::TRK_W'($urandom_range(999, 0)));
                settle();
            end
        end while (pick_id >= 0);

        repeat (30) @(posedge i_clk);
        if (due_outcomes.size() != 0)
            flag_error($sformatf("%0d predictions never answered", due_outcomes.size()));
        $display("Run: %0d commands over %0d register settings, %0d results checked,",
                 n_taken, n_settings, n_checked);
        $display("     %0d serves, %0d rejections, %0d requesters retired, %0d mismatches.",
                 n_serves, n_rejects, $countones(retired_mask), n_errors);
        if (n_errors == 0) begin
            $display("sstf_disk_request_scheduler_tb: done, clean");
        end else begin
            $display("sstf_disk_request_scheduler_tb: done, errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("sstf_disk_request_scheduler_tb: done, errors");
        $finish;
    end

endmodule
